// File: rtl/pst_pkg.sv
// package: op and status codes, cell control types for the piece slot table
package pst_pkg;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_READ    = 3'd1,
        OP_COMMIT  = 3'd2,
        OP_PROTECT = 3'd3,
        OP_CLOSE   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_MISSING = 3'd2,
        ST_RANGE   = 3'd3,
        ST_HASH    = 3'd4,
        ST_CLOSED  = 3'd5
    } status_t;

    // what a cell holds
    typedef struct packed {
        logic        valid;
        logic [31:0] piece;
        logic        committed;
        logic [31:0] last_access;
        logic        selected;
        logic        locked;
    } entry_t;

    // update command applied to the cell at the head of the ring
    typedef struct packed {
        logic        clear;     // close: empty the cell
        logic        touch;     // set access time
        logic        take;      // load new piece, clear marks
        logic        uncommit;
        logic        protect;
        logic        commit;
        logic [31:0] piece;
        logic [31:0] now;
        logic        sel;
        logic        lck;
    } cell_cmd_t;

endpackage

// File: rtl/pst_if.sv
// valid/ready channel interface
interface pst_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/piece_slot_table_lru.sv
// top level: piece slot table with lru replacement built as a ring of cells
// operation: a scan lap of the ring, then an update lap; the result is registered at
//   the end of the update lap and held as long as the receiver stalls
// input ready only while idle, so a new transaction is not taken until the result has
//   been accepted; during the scan and update laps one cell visits the head per cycle
// reset: all slots empty (piece all ones), table open, no result pending
module piece_slot_table_lru
    import pst_pkg::*;
#(
    parameter int SLOTS = 16
)(
    input logic clk,
    input logic rst_n,
    pst_if.sink   in_ch,
    pst_if.source out_ch
);
    localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // latched transaction fields
    logic [2:0]  op_reg;
    logic [31:0] piece_reg, rend_reg, now_reg;
    logic        sel_reg, lck_reg, hok_reg;
    logic        closed_reg;

    // position of the cell at the ring head (original slot index)
    logic [CW-1:0] pos_reg;

    // scan results
    logic          hit_reg;
    logic [CW-1:0] hit_idx_reg;
    logic          empty_reg;
    logic [CW-1:0] empty_idx_reg;
    logic          ev_reg;
    logic [CW-1:0] ev_idx_reg;
    logic [31:0]   ev_time_reg, ev_piece_reg;
    logic [KW-1:0] have_reg;

    // decision after scan
    logic          tgt_ok;
    logic [CW-1:0] tgt_idx;
    status_t       st_dec;

    // ring of cells: cell 0 is the head; data moves toward lower index,
    // head feeds the tail
    entry_t ring [SLOTS];
    entry_t head;
    logic   shift;
    logic   apply;
    cell_cmd_t cmd;

    assign head  = ring[0];
    assign shift = (state_reg == S_SCAN) || (state_reg == S_UPDATE);

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        entry_t din_g;
        if (g == SLOTS - 1)
        begin : g_tail
            assign din_g = ring[0];
        end
        else
        begin : g_mid
            assign din_g = ring[g+1];
        end
        // the command applies as the head entry moves into the tail
        pst_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .apply (apply && (g == SLOTS - 1)),
            .cmd   (cmd),
            .din   (din_g),
            .dout  (ring[g])
        );
    end

    // range membership of the head entry
    logic in_range;
    assign in_range = head.valid && (head.piece >= piece_reg) && (head.piece <= rend_reg);

    // 33-bit range size, compared with the count
    logic [32:0] need;
    assign need = {1'b0, rend_reg} - {1'b0, piece_reg} + 33'd1;

    logic last_pos;
    assign last_pos = (pos_reg == CW'(SLOTS - 1));

    always_comb
    begin
        tgt_ok  = 1'b0;
        tgt_idx = '0;
        st_dec  = ST_OK;
        if (op_reg == OP_CLOSE)
            st_dec = ST_OK;
        else if (op_reg <= OP_PROTECT && closed_reg)
            st_dec = ST_CLOSED;
        else
        begin
            unique case (op_reg)
                OP_WRITE:
                begin
                    priority if (hit_reg)
                    begin
                        tgt_ok = 1'b1; tgt_idx = hit_idx_reg;
                    end
                    else if (empty_reg)
                    begin
                        tgt_ok = 1'b1; tgt_idx = empty_idx_reg;
                    end
                    else if (ev_reg)
                    begin
                        tgt_ok = 1'b1; tgt_idx = ev_idx_reg;
                    end
                    else
                        st_dec = ST_FULL;
                end
                OP_READ, OP_PROTECT:
                begin
                    if (hit_reg)
                    begin
                        tgt_ok = 1'b1; tgt_idx = hit_idx_reg;
                    end
                    else
                        st_dec = ST_MISSING;
                end
                OP_COMMIT:
                begin
                    priority if (piece_reg > rend_reg)
                        st_dec = ST_RANGE;
                    else if ({{(33-KW){1'b0}}, have_reg} != need)
                        st_dec = ST_MISSING;
                    else if (!hok_reg)
                        st_dec = ST_HASH;
                    else
                        st_dec = ST_OK;
                end
                default: st_dec = ST_OK;
            endcase
        end
    end

    // update command for the head cell
    logic do_op;
    assign do_op = (op_reg == OP_CLOSE) || !closed_reg;

    always_comb
    begin
        cmd       = '0;
        cmd.piece = piece_reg;
        cmd.now   = now_reg;
        cmd.sel   = sel_reg;
        cmd.lck   = lck_reg;
        apply     = 1'b0;
        if (state_reg == S_UPDATE && do_op)
        begin
            apply = 1'b1;
            unique case (op_reg)
                OP_CLOSE:  cmd.clear = 1'b1;
                OP_WRITE:
                begin
                    if (tgt_ok && pos_reg == tgt_idx)
                    begin
                        cmd.touch    = 1'b1;
                        cmd.uncommit = 1'b1;
                        cmd.take     = !hit_reg;
                    end
                end
                OP_READ:    cmd.touch = tgt_ok && (pos_reg == tgt_idx);
                OP_PROTECT: cmd.protect = tgt_ok && (pos_reg == tgt_idx);
                OP_COMMIT:  cmd.commit = (st_dec == ST_OK) && in_range;
                default:    apply = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_ch.valid) state_next = S_SCAN;
            S_SCAN:   if (last_pos) state_next = S_UPDATE;
            S_UPDATE: if (last_pos) state_next = S_OUT;
            S_OUT:    if (out_ch.ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);

    // output register
    status_t     st_reg;
    logic [7:0]  slot_reg;
    logic        evv_reg;
    logic [31:0] evp_reg;

    assign out_ch.data = '{status: st_reg, slot: slot_reg,
                           evicted_valid: evv_reg, evicted_piece: evp_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            closed_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (shift)
                pos_reg <= last_pos ? '0 : pos_reg + CW'(1);
            if (state_reg == S_UPDATE && last_pos && op_reg == OP_CLOSE)
                closed_reg <= 1'b1;
        end
    end

    // datapath registers
    logic evictable;
    assign evictable = head.valid && head.committed && !head.selected && !head.locked;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            op_reg    <= in_ch.data.op;
            piece_reg <= in_ch.data.piece;
            rend_reg  <= in_ch.data.range_end;
            now_reg   <= in_ch.data.now;
            sel_reg   <= in_ch.data.selected_flag;
            lck_reg   <= in_ch.data.locked_flag;
            hok_reg   <= in_ch.data.hash_ok;
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
            ev_reg    <= 1'b0;
            have_reg  <= '0;
        end
        if (state_reg == S_SCAN)
        begin
            if (!hit_reg && head.valid && head.piece == piece_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= pos_reg;
            end
            if (!empty_reg && !head.valid)
            begin
                empty_reg     <= 1'b1;
                empty_idx_reg <= pos_reg;
            end
            if (evictable && (!ev_reg || ev_time_reg > head.last_access))
            begin
                ev_reg       <= 1'b1;
                ev_idx_reg   <= pos_reg;
                ev_time_reg  <= head.last_access;
                ev_piece_reg <= head.piece;
            end
            if (in_range)
                have_reg <= have_reg + KW'(1);
        end
        if (state_reg == S_UPDATE && last_pos)
        begin
            st_reg   <= st_dec;
            slot_reg <= tgt_ok ? 8'(tgt_idx) : 8'd0;
            evv_reg  <= (st_dec == ST_OK) && op_reg == OP_WRITE && tgt_ok
                        && !hit_reg && !empty_reg;
            evp_reg  <= ((st_dec == ST_OK) && op_reg == OP_WRITE && tgt_ok
                        && !hit_reg && !empty_reg) ? ev_piece_reg : 32'd0;
        end
    end
endmodule

// File: rtl/pst_cell.sv
// one slot cell: holds an entry, applies a command, passes it to its neighbor
module pst_cell
    import pst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift,
    input  logic      apply,
    input  cell_cmd_t cmd,
    input  entry_t    din,
    output entry_t    dout
);
    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        ent_next = din;
        if (apply)
        begin
            if (cmd.clear)
            begin
                ent_next = '{valid: 1'b0, piece: '1, committed: 1'b0,
                             last_access: '0, selected: 1'b0, locked: 1'b0};
            end
            else
            begin
                if (cmd.take)
                begin
                    ent_next.valid    = 1'b1;
                    ent_next.piece    = cmd.piece;
                    ent_next.selected = 1'b0;
                    ent_next.locked   = 1'b0;
                end
                if (cmd.take || cmd.uncommit)
                    ent_next.committed = 1'b0;
                if (cmd.commit)
                    ent_next.committed = 1'b1;
                if (cmd.touch)
                    ent_next.last_access = cmd.now;
                if (cmd.protect)
                begin
                    ent_next.selected = cmd.sel;
                    ent_next.locked   = cmd.lck;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '{valid: 1'b0, piece: '1, committed: 1'b0,
                         last_access: '0, selected: 1'b0, locked: 1'b0};
        else if (shift)
            ent_reg <= ent_next;
    end

    assign dout = ent_reg;
endmodule

// File: tb/piece_slot_table_lru_tb.sv
// testbench: piece slot table with lru replacement, self-checking against a predictor
module piece_slot_table_lru_tb
    import pst_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int N_RANDOM   = 1100;
    localparam int STALL_LONG = 300;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN      = 2 * SLOTS + 10;

    // transaction layouts as carried on the two channels
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] piece;
        logic [31:0] range_end;
        logic [31:0] now;
        logic        selected_flag;
        logic        locked_flag;
        logic        hash_ok;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic        evicted_valid;
        logic [31:0] evicted_piece;
    } rsp_t;

    // scoreboard: keeps its own copy of the table and a queue of expected responses
    class slot_table_scoreboard;
        bit          held[SLOTS];
        logic [31:0] pc[SLOTS];
        bit          com[SLOTS];
        logic [31:0] acc[SLOTS];
        bit          sel[SLOTS];
        bit          lck[SLOTS];
        bit          is_closed;
        rsp_t        pending[$];
        int          mismatches;
        int          n_checked;
        int          n_evict;
        int          n_full;
        int          n_commit_ok;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                empty_slot(i);
            end
            is_closed = 0;
        endfunction

        function void empty_slot(int i);
            held[i] = 0;
            pc[i]   = '1;
            com[i]  = 0;
            acc[i]  = '0;
            sel[i]  = 0;
            lck[i]  = 0;
        endfunction

        function int find_piece(logic [31:0] p);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (held[i] && pc[i] == p)
                    return i;
            end
            return -1;
        endfunction

        // predict the response of one accepted request and update the table
        function void note_request(req_t r);
            rsp_t        e;
            int          s;
            logic [63:0] need;
            logic [63:0] have;
            e = '0;
            e.status = ST_OK;
            if (r.op == OP_CLOSE)
            begin
                for (int i = 0; i < SLOTS; i++)
                    empty_slot(i);
                is_closed = 1;
            end
            else if (r.op <= OP_PROTECT && is_closed)
                e.status = ST_CLOSED;
            else if (r.op == OP_WRITE)
            begin
                s = find_piece(r.piece);
                if (s >= 0)
                begin
                    com[s] = 0;
                    acc[s] = r.now;
                    e.slot = 8'(s);
                end
                else
                begin
                    for (int i = 0; i < SLOTS && s < 0; i++)
                        if (!held[i])
                            s = i;
                    if (s < 0)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (held[i] && com[i] && !sel[i] && !lck[i] &&
                                (s < 0 || acc[s] > acc[i]))
                                s = i;
                        if (s >= 0)
                        begin
                            e.evicted_valid = 1;
                            e.evicted_piece = pc[s];
                            n_evict++;
                        end
                    end
                    if (s < 0)
                    begin
                        e.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        held[s] = 1;
                        pc[s]   = r.piece;
                        com[s]  = 0;
                        acc[s]  = r.now;
                        sel[s]  = 0;
                        lck[s]  = 0;
                        e.slot  = 8'(s);
                    end
                end
            end
            else if (r.op == OP_READ)
            begin
                s = find_piece(r.piece);
                if (s < 0)
                    e.status = ST_MISSING;
                else
                begin
                    acc[s] = r.now;
                    e.slot = 8'(s);
                end
            end
            else if (r.op == OP_COMMIT)
            begin
                if (r.piece > r.range_end)
                    e.status = ST_RANGE;
                else
                begin
                    need = {32'd0, r.range_end} - {32'd0, r.piece} + 64'd1;
                    have = '0;
                    for (int i = 0; i < SLOTS; i++)
                        if (held[i] && pc[i] >= r.piece && pc[i] <= r.range_end)
                            have++;
                    if (have != need)
                        e.status = ST_MISSING;
                    else if (!r.hash_ok)
                        e.status = ST_HASH;
                    else
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (held[i] && pc[i] >= r.piece && pc[i] <= r.range_end)
                                com[i] = 1;
                        n_commit_ok++;
                    end
                end
            end
            else if (r.op == OP_PROTECT)
            begin
                s = find_piece(r.piece);
                if (s < 0)
                    e.status = ST_MISSING;
                else
                begin
                    sel[s] = r.selected_flag;
                    lck[s] = r.locked_flag;
                    e.slot = 8'(s);
                end
            end
            pending.insert(pending.size(), e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch on response %0d: %s got %0h expected %0h",
                     $realtime, n_checked, what, got, want);
            mismatches++;
        endtask

        task check_response(rsp_t got);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $display("[%0t] response with no request outstanding", $realtime);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report("status", 32'(got.status), 32'(e.status));
            if (got.slot !== e.slot)
                report("slot", 32'(got.slot), 32'(e.slot));
            if (got.evicted_valid !== e.evicted_valid)
                report("evicted_valid", 32'(got.evicted_valid), 32'(e.evicted_valid));
            if (got.evicted_piece !== e.evicted_piece)
                report("evicted_piece", got.evicted_piece, e.evicted_piece);
            n_checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    pst_if #(.payload_t(req_t)) in_ch ();
    pst_if #(.payload_t(rsp_t)) out_ch ();

    piece_slot_table_lru #(.SLOTS(SLOTS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    slot_table_scoreboard sb;
    req_t   stim[$];
    bit     hold_request;   // asks the response side for one long stall
    int     idle_cycles;
    logic [31:0] clock_now; // running time stamp handed to the block
    logic [31:0] pool_base; // piece numbers cluster around this so hits and evictions occur

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("** piece_slot_table_lru: FAILED **");
            $finish;
        end
    end

    function automatic req_t mk(logic [2:0] op, logic [31:0] p, logic [31:0] e,
                                logic [31:0] t, bit s, bit l, bit h);
        req_t r;
        r.op            = op;
        r.piece         = p;
        r.range_end     = e;
        r.now           = t;
        r.selected_flag = s;
        r.locked_flag   = l;
        r.hash_ok       = h;
        return r;
    endfunction

    // append one request to the stimulus queue
    function automatic void add_req(req_t r);
        stim.insert(stim.size(), r);
    endfunction

    // one random request, mostly well formed against a small cluster of pieces
    function automatic req_t random_request();
        req_t        r;
        int          k;
        int          pick;
        logic [31:0] t;
        k = $urandom_range(0, 23);
        pick = $urandom_range(0, 99);
        // time normally runs forward; sometimes random, sometimes frozen to make ties
        if ($urandom_range(0, 9) == 0)
            t = $urandom;
        else if ($urandom_range(0, 4) == 0)
            t = clock_now;
        else
        begin
            clock_now = clock_now + $urandom_range(1, 5);
            t = clock_now;
        end
        r = mk(OP_WRITE, pool_base + k, $urandom, t, $urandom_range(0, 1),
               $urandom_range(0, 1), $urandom_range(0, 1));
        if (pick < 38)
            r.op = OP_WRITE;
        else if (pick < 55)
            r.op = OP_READ;
        else if (pick < 80)
        begin
            // commit of a short run, hash usually good
            r.op = OP_COMMIT;
            r.range_end = pool_base + k + $urandom_range(0, 2);
            r.hash_ok = ($urandom_range(0, 7) != 0);
        end
        else if (pick < 92)
        begin
            r.op = OP_PROTECT;
            r.selected_flag = ($urandom_range(0, 3) == 0);
            r.locked_flag   = ($urandom_range(0, 3) == 0);
        end
        else if (pick < 97)
        begin
            // noise: fully random fields
            r.op = 3'($urandom_range(0, 3));
            r.piece = $urandom;
            r.range_end = $urandom;
        end
        else
            r.op = 3'($urandom_range(5, 7));    // unused codes, ignored by the block
        return r;
    endfunction

    // request side: random gaps, valid held until accepted
    task automatic drive_requests();
        req_t r;
        int   gap;
        while (stim.size() > 0)
        begin
            r = stim.pop_front();
            gap = $urandom_range(0, 6);
            if (stim.size() % 200 < 30)
                gap = 0;        // stretches with no idling
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.data  <= r;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            sb.note_request(r);
        end
        in_ch.valid <= 1'b0;
    endtask

    // response side: random stalls plus one long hold-off so the block backs up
    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                out_ch.ready <= 1'b0;
                repeat (STALL_LONG) @(posedge clk);
            end
            else
            begin
                gap = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0)
                    gap = 0;
                if (gap > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            sb.check_response(out_ch.data);
        end
    end

    initial
    begin
        sb = new();
        idle_cycles = 0;
        hold_request = 0;
        clock_now = 32'd100;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every op but close, each corner case
        add_req(mk(OP_WRITE, 32'h0, 32'h0, 32'h0, 0, 0, 0));
        add_req(mk(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1));
        add_req(mk(OP_READ, 32'h0, 32'h0, 32'h5, 0, 0, 0));
        add_req(mk(OP_READ, 32'h5, 32'h0, 32'h6, 0, 0, 0));            // not held
        add_req(mk(OP_COMMIT, 32'h1, 32'h0, 32'h7, 0, 0, 1));          // start above end
        add_req(mk(OP_COMMIT, 32'h0, 32'h0, 32'h8, 0, 0, 0));          // hash bad
        add_req(mk(OP_COMMIT, 32'h0, 32'hFFFF_FFFF, 32'h9, 0, 0, 1));  // pieces missing
        add_req(mk(OP_COMMIT, 32'h0, 32'h0, 32'ha, 0, 0, 1));
        add_req(mk(OP_COMMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hb, 0, 0, 1));
        add_req(mk(OP_PROTECT, 32'hFFFF_FFFF, 32'h0, 32'hc, 1, 1, 0));
        add_req(mk(OP_PROTECT, 32'h1234, 32'h0, 32'hd, 1, 0, 0));      // not held
        add_req(mk(OP_WRITE, 32'h0, 32'h0, 32'he, 0, 0, 0));           // rewrite held piece
        add_req(mk(3'd5, 32'h0, 32'h0, 32'h0, 0, 0, 0));
        add_req(mk(3'd6, 32'h0, 32'h0, 32'h0, 0, 0, 0));
        add_req(mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1));
        // fill with uncommitted pieces; the last write of the loop and the one after it find the table full
        for (int i = 1; i <= 15; i++)
            add_req(mk(OP_WRITE, 32'h100 + i, 32'h0, 32'h20 + i, 0, 0, 0));
        add_req(mk(OP_WRITE, 32'h200, 32'h0, 32'h40, 0, 0, 0));
        drive_requests();

        // random: piece cluster moves now and then so every bit of piece toggles
        pool_base = 32'h300;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 150 == 149)
                pool_base = $urandom_range(0, 32'hFFFF_FFE0);
            add_req(random_request());
        end
        // closing: close, later ops report closed, a second close is fine
        add_req(mk(OP_CLOSE, 32'h0, 32'h0, 32'h0, 0, 0, 0));
        add_req(mk(OP_WRITE, 32'h1, 32'h0, 32'h1, 0, 0, 0));
        add_req(mk(OP_READ, 32'h1, 32'h0, 32'h1, 0, 0, 0));
        add_req(mk(OP_COMMIT, 32'h1, 32'h1, 32'h1, 0, 0, 1));
        add_req(mk(OP_PROTECT, 32'h1, 32'h0, 32'h1, 1, 1, 0));
        add_req(mk(OP_CLOSE, 32'h0, 32'h0, 32'h0, 0, 0, 0));
        add_req(mk(OP_WRITE, 32'h2, 32'h0, 32'h2, 0, 0, 0));
        fork
            drive_requests();
            begin
                // long receiver stall partway through while requests keep coming
                repeat (5000) @(posedge clk);
                hold_request = 1;
            end
        join

        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("checked %0d responses: %0d evictions, %0d table-full, %0d commits accepted",
                 sb.n_checked, sb.n_evict, sb.n_full, sb.n_commit_ok);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** piece_slot_table_lru: PASSED **");
        else
            $display("** piece_slot_table_lru: FAILED **");
        $finish;
    end

endmodule
